[design/sqltok_pkg.sv]
// ---------------------------------------------------------------------------
// sqltok_pkg: shared types and constants of the sql byte tokenizer
// Token class codes, scanner mode codes, scanner state record, token record
// and the keyword lookup used by the scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package sqltok_pkg;

  // default width of the byte position counter
  localparam int OFFSET_BITS_DEF = 32;

  // token field widths
  localparam int CLS_W   = 6;
  localparam int LEN_W   = 32;
  localparam int RES_MAX = 3;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // token classes
  localparam logic [CLS_W-1:0] CLS_STRAY  = 6'd0;
  localparam logic [CLS_W-1:0] CLS_LPAREN = 6'd1;
  localparam logic [CLS_W-1:0] CLS_RPAREN = 6'd2;
  localparam logic [CLS_W-1:0] CLS_COMMA  = 6'd3;
  localparam logic [CLS_W-1:0] CLS_SEMI   = 6'd4;
  localparam logic [CLS_W-1:0] CLS_STAR   = 6'd5;
  localparam logic [CLS_W-1:0] CLS_DOT    = 6'd6;
  localparam logic [CLS_W-1:0] CLS_EQ     = 6'd7;
  localparam logic [CLS_W-1:0] CLS_GT     = 6'd8;
  localparam logic [CLS_W-1:0] CLS_GE     = 6'd9;
  localparam logic [CLS_W-1:0] CLS_LT     = 6'd10;
  localparam logic [CLS_W-1:0] CLS_LE     = 6'd11;
  localparam logic [CLS_W-1:0] CLS_STR    = 6'd12;
  localparam logic [CLS_W-1:0] CLS_INT    = 6'd13;
  localparam logic [CLS_W-1:0] CLS_DEC    = 6'd14;
  localparam logic [CLS_W-1:0] CLS_IDENT  = 6'd15;
  localparam logic [CLS_W-1:0] CLS_KW_BY       = 6'd16;
  localparam logic [CLS_W-1:0] CLS_KW_ON       = 6'd17;
  localparam logic [CLS_W-1:0] CLS_KW_OR       = 6'd18;
  localparam logic [CLS_W-1:0] CLS_KW_IF       = 6'd19;
  localparam logic [CLS_W-1:0] CLS_KW_INT      = 6'd20;
  localparam logic [CLS_W-1:0] CLS_KW_ASC      = 6'd21;
  localparam logic [CLS_W-1:0] CLS_KW_AND      = 6'd22;
  localparam logic [CLS_W-1:0] CLS_KW_KEY      = 6'd23;
  localparam logic [CLS_W-1:0] CLS_KW_NOT      = 6'd24;
  localparam logic [CLS_W-1:0] CLS_KW_FROM     = 6'd25;
  localparam logic [CLS_W-1:0] CLS_KW_JOIN     = 6'd26;
  localparam logic [CLS_W-1:0] CLS_KW_DESC     = 6'd27;
  localparam logic [CLS_W-1:0] CLS_KW_NULL     = 6'd28;
  localparam logic [CLS_W-1:0] CLS_KW_INTO     = 6'd29;
  localparam logic [CLS_W-1:0] CLS_KW_TEXT     = 6'd30;
  localparam logic [CLS_W-1:0] CLS_KW_TABLE    = 6'd31;
  localparam logic [CLS_W-1:0] CLS_KW_WHERE    = 6'd32;
  localparam logic [CLS_W-1:0] CLS_KW_ORDER    = 6'd33;
  localparam logic [CLS_W-1:0] CLS_KW_FLOAT    = 6'd34;
  localparam logic [CLS_W-1:0] CLS_KW_INNER    = 6'd35;
  localparam logic [CLS_W-1:0] CLS_KW_CREATE   = 6'd36;
  localparam logic [CLS_W-1:0] CLS_KW_INSERT   = 6'd37;
  localparam logic [CLS_W-1:0] CLS_KW_SELECT   = 6'd38;
  localparam logic [CLS_W-1:0] CLS_KW_DELETE   = 6'd39;
  localparam logic [CLS_W-1:0] CLS_KW_EXISTS   = 6'd40;
  localparam logic [CLS_W-1:0] CLS_KW_VALUES   = 6'd41;
  localparam logic [CLS_W-1:0] CLS_KW_PRIMARY  = 6'd42;
  localparam logic [CLS_W-1:0] CLS_KW_VARCHAR  = 6'd43;
  localparam logic [CLS_W-1:0] CLS_KW_DATETIME = 6'd44;

  // characters with a role of their own
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CASE   = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // longest keyword and saturation of the word length
  localparam int               KW_MAX_LEN = 8;
  localparam logic [3:0]       WCNT_FULL  = 4'd8;
  localparam logic [3:0]       WCNT_SAT   = 4'd9;

  // scanner modes
  typedef enum logic [7:0] {
    MODE_IDLE  = 8'b0000_0001,
    MODE_STR   = 8'b0000_0010,
    MODE_ESC   = 8'b0000_0100,
    MODE_NUM   = 8'b0000_1000,
    MODE_WORD  = 8'b0001_0000,
    MODE_MINUS = 8'b0010_0000,
    MODE_GT    = 8'b0100_0000,
    MODE_LT    = 8'b1000_0000
  } mode_t;

  // scanner state apart from the offsets
  typedef struct packed {
    mode_t             mode;
    logic              quote_dbl;
    logic              seen_dot;
    logic [63:0]       prefix;     // word bytes, first byte highest
    logic [3:0]        wcnt;
    logic [LEN_W-1:0]  raw_cnt;
    logic [LEN_W-1:0]  val_cnt;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{mode: MODE_IDLE, default: '0};

  // one result token
  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] raw;
    logic [LEN_W-1:0] val;
    logic             eot;
  } tok_t;

  // saturating length increment
  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? v : v + LEN_W'(1);
  endfunction

  // keyword lookup on the lower-cased word prefix
  function automatic logic [CLS_W-1:0] kw_class(input logic [63:0] p,
                                                input logic [3:0]  n);
    logic [CLS_W-1:0] cls;
    cls = CLS_IDENT;
    if (n <= WCNT_FULL) begin
      case (p)
        {48'd0, "by"}:       cls = CLS_KW_BY;
        {48'd0, "on"}:       cls = CLS_KW_ON;
        {48'd0, "or"}:       cls = CLS_KW_OR;
        {48'd0, "if"}:       cls = CLS_KW_IF;
        {40'd0, "int"}:      cls = CLS_KW_INT;
        {40'd0, "asc"}:      cls = CLS_KW_ASC;
        {40'd0, "and"}:      cls = CLS_KW_AND;
        {40'd0, "key"}:      cls = CLS_KW_KEY;
        {40'd0, "not"}:      cls = CLS_KW_NOT;
        {32'd0, "from"}:     cls = CLS_KW_FROM;
        {32'd0, "join"}:     cls = CLS_KW_JOIN;
        {32'd0, "desc"}:     cls = CLS_KW_DESC;
        {32'd0, "null"}:     cls = CLS_KW_NULL;
        {32'd0, "into"}:     cls = CLS_KW_INTO;
        {32'd0, "text"}:     cls = CLS_KW_TEXT;
        {24'd0, "table"}:    cls = CLS_KW_TABLE;
        {24'd0, "where"}:    cls = CLS_KW_WHERE;
        {24'd0, "order"}:    cls = CLS_KW_ORDER;
        {24'd0, "float"}:    cls = CLS_KW_FLOAT;
        {24'd0, "inner"}:    cls = CLS_KW_INNER;
        {16'd0, "create"}:   cls = CLS_KW_CREATE;
        {16'd0, "insert"}:   cls = CLS_KW_INSERT;
        {16'd0, "select"}:   cls = CLS_KW_SELECT;
        {16'd0, "delete"}:   cls = CLS_KW_DELETE;
        {16'd0, "double"}:   cls = CLS_KW_FLOAT;
        {16'd0, "exists"}:   cls = CLS_KW_EXISTS;
        {16'd0, "values"}:   cls = CLS_KW_VALUES;
        {8'd0, "primary"}:   cls = CLS_KW_PRIMARY;
        {8'd0, "integer"}:   cls = CLS_KW_INT;
        {8'd0, "varchar"}:   cls = CLS_KW_VARCHAR;
        {8'd0, "decimal"}:   cls = CLS_KW_FLOAT;
        "datetime":          cls = CLS_KW_DATETIME;
        default:             cls = CLS_IDENT;
      endcase
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

[design/sqltok_scan.sv]
// ---------------------------------------------------------------------------
// sqltok_scan: per-byte scanner step
// Takes the current scanner state and one byte, gives the next state and up
// to three tokens caused by that byte, in order.
// ---------------------------------------------------------------------------
`default_nettype none

module sqltok_scan #(
  parameter int OFFSET_BITS = sqltok_pkg::OFFSET_BITS_DEF
) (
  input  wire logic [7:0]               byte_i,
  input  wire logic                     last_i,
  input  wire sqltok_pkg::scan_state_t  st_i,
  input  wire logic [OFFSET_BITS-1:0]   pos_i,
  input  wire logic [OFFSET_BITS-1:0]   start_i,
  output sqltok_pkg::scan_state_t       st_o,
  output logic [OFFSET_BITS-1:0]        pos_o,
  output logic [OFFSET_BITS-1:0]        start_o,
  output sqltok_pkg::tok_t              tok_o [sqltok_pkg::RES_MAX],
  output logic [1:0]                    cnt_o
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  // build a token record
  function automatic sqltok_pkg::tok_t mk_tok(
    input logic [sqltok_pkg::CLS_W-1:0] cls,
    input logic [OFFSET_BITS-1:0]       start,
    input logic [sqltok_pkg::LEN_W-1:0] raw,
    input logic [sqltok_pkg::LEN_W-1:0] val,
    input logic                         eot
  );
    sqltok_pkg::tok_t t;
    t.cls   = cls;
    t.start = sqltok_pkg::LEN_W'(start);
    t.raw   = raw;
    t.val   = val;
    t.eot   = eot;
    return t;
  endfunction

  logic c_space, c_digit, c_alpha, c_word;

  // byte classes
  always_comb begin
    c_space = byte_i inside {sqltok_pkg::CH_SPACE, [8'h09:8'h0D]};
    c_digit = byte_i inside {[8'h30:8'h39]};
    c_alpha = byte_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    c_word  = c_alpha || c_digit || (byte_i == sqltok_pkg::CH_USCORE);
  end

  // scanner step: open token, fresh scan, then flush and end token on last
  always_comb begin
    sqltok_pkg::scan_state_t st;
    logic [OFFSET_BITS-1:0]  start;
    logic [OFFSET_BITS-1:0]  pos;
    logic [1:0]              n;
    logic                    rescan;
    logic [7:0]              quote;

    st     = st_i;
    start  = start_i;
    pos    = pos_i;
    n      = 2'd0;
    rescan = 1'b0;
    quote  = st_i.quote_dbl ? sqltok_pkg::CH_DQUOTE : sqltok_pkg::CH_SQUOTE;
    for (int i = 0; i < sqltok_pkg::RES_MAX; i++) begin
      tok_o[i] = '0;
    end

    // continue the open token
    case (st_i.mode)
      sqltok_pkg::MODE_STR: begin
        st.raw_cnt = sqltok_pkg::sat_inc(st_i.raw_cnt);
        if (byte_i == quote) begin
          tok_o[n] = mk_tok(sqltok_pkg::CLS_STR, start, st.raw_cnt, st_i.val_cnt, 1'b0);
          n = n + 2'd1;
          st.mode = sqltok_pkg::MODE_IDLE;
        end else if (byte_i == sqltok_pkg::CH_BSLASH) begin
          st.mode = sqltok_pkg::MODE_ESC;
        end else begin
          st.val_cnt = sqltok_pkg::sat_inc(st_i.val_cnt);
        end
      end
      sqltok_pkg::MODE_ESC: begin
        st.raw_cnt = sqltok_pkg::sat_inc(st_i.raw_cnt);
        st.val_cnt = sqltok_pkg::sat_inc(st_i.val_cnt);
        st.mode    = sqltok_pkg::MODE_STR;
      end
      sqltok_pkg::MODE_NUM: begin
        if (c_digit || (byte_i == sqltok_pkg::CH_DOT && !st_i.seen_dot)) begin
          if (byte_i == sqltok_pkg::CH_DOT) st.seen_dot = 1'b1;
          st.raw_cnt = sqltok_pkg::sat_inc(st_i.raw_cnt);
        end else begin
          tok_o[n] = mk_tok(st_i.seen_dot ? sqltok_pkg::CLS_DEC : sqltok_pkg::CLS_INT,
                            start, st_i.raw_cnt, st_i.raw_cnt, 1'b0);
          n = n + 2'd1;
          rescan = 1'b1;
        end
      end
      sqltok_pkg::MODE_WORD: begin
        if (c_word) begin
          if (st_i.wcnt < sqltok_pkg::WCNT_FULL)
            st.prefix = {st_i.prefix[55:0], byte_i | sqltok_pkg::CH_CASE};
          if (st_i.wcnt < sqltok_pkg::WCNT_SAT) st.wcnt = st_i.wcnt + 4'd1;
          st.raw_cnt = sqltok_pkg::sat_inc(st_i.raw_cnt);
        end else begin
          tok_o[n] = mk_tok(sqltok_pkg::kw_class(st_i.prefix, st_i.wcnt),
                            start, st_i.raw_cnt, st_i.raw_cnt, 1'b0);
          n = n + 2'd1;
          rescan = 1'b1;
        end
      end
      sqltok_pkg::MODE_MINUS: begin
        if (c_digit) begin
          st.mode     = sqltok_pkg::MODE_NUM;
          st.raw_cnt  = sqltok_pkg::LEN_W'(2);
          st.seen_dot = 1'b0;
        end else begin
          tok_o[n] = mk_tok(sqltok_pkg::CLS_STRAY, start, sqltok_pkg::LEN_W'(1),
                            sqltok_pkg::LEN_W'(1), 1'b0);
          n = n + 2'd1;
          rescan = 1'b1;
        end
      end
      sqltok_pkg::MODE_GT, sqltok_pkg::MODE_LT: begin
        if (byte_i == "=") begin
          tok_o[n] = mk_tok((st_i.mode == sqltok_pkg::MODE_GT) ? sqltok_pkg::CLS_GE
                                                               : sqltok_pkg::CLS_LE,
                            start, sqltok_pkg::LEN_W'(2), sqltok_pkg::LEN_W'(2), 1'b0);
          n = n + 2'd1;
          st.mode = sqltok_pkg::MODE_IDLE;
        end else begin
          tok_o[n] = mk_tok((st_i.mode == sqltok_pkg::MODE_GT) ? sqltok_pkg::CLS_GT
                                                               : sqltok_pkg::CLS_LT,
                            start, sqltok_pkg::LEN_W'(1), sqltok_pkg::LEN_W'(1), 1'b0);
          n = n + 2'd1;
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // fresh scan of the byte from idle
    if (rescan) begin
      st.mode = sqltok_pkg::MODE_IDLE;
      if (!c_space) begin
        case (byte_i)
          "(", ")", ",", ";", "*", ".", "=": begin
            case (byte_i)
              "(":     tok_o[n] = mk_tok(sqltok_pkg::CLS_LPAREN, pos, 32'd1, 32'd1, 1'b0);
              ")":     tok_o[n] = mk_tok(sqltok_pkg::CLS_RPAREN, pos, 32'd1, 32'd1, 1'b0);
              ",":     tok_o[n] = mk_tok(sqltok_pkg::CLS_COMMA, pos, 32'd1, 32'd1, 1'b0);
              ";":     tok_o[n] = mk_tok(sqltok_pkg::CLS_SEMI, pos, 32'd1, 32'd1, 1'b0);
              "*":     tok_o[n] = mk_tok(sqltok_pkg::CLS_STAR, pos, 32'd1, 32'd1, 1'b0);
              ".":     tok_o[n] = mk_tok(sqltok_pkg::CLS_DOT, pos, 32'd1, 32'd1, 1'b0);
              default: tok_o[n] = mk_tok(sqltok_pkg::CLS_EQ, pos, 32'd1, 32'd1, 1'b0);
            endcase
            n = n + 2'd1;
          end
          default: begin
            if (byte_i == ">" || byte_i == "<" || byte_i == sqltok_pkg::CH_SQUOTE ||
                byte_i == sqltok_pkg::CH_DQUOTE || byte_i == sqltok_pkg::CH_MINUS ||
                c_digit || c_alpha || byte_i == sqltok_pkg::CH_USCORE) begin
              // open a new token here
              start       = pos;
              st.raw_cnt  = sqltok_pkg::LEN_W'(1);
              st.val_cnt  = '0;
              st.seen_dot = 1'b0;
              st.prefix   = '0;
              st.wcnt     = '0;
              if (byte_i == ">") begin
                st.mode = sqltok_pkg::MODE_GT;
              end else if (byte_i == "<") begin
                st.mode = sqltok_pkg::MODE_LT;
              end else if (byte_i == sqltok_pkg::CH_SQUOTE ||
                           byte_i == sqltok_pkg::CH_DQUOTE) begin
                st.mode      = sqltok_pkg::MODE_STR;
                st.quote_dbl = (byte_i == sqltok_pkg::CH_DQUOTE);
              end else if (byte_i == sqltok_pkg::CH_MINUS) begin
                st.mode = sqltok_pkg::MODE_MINUS;
              end else if (c_digit) begin
                st.mode = sqltok_pkg::MODE_NUM;
              end else begin
                st.mode   = sqltok_pkg::MODE_WORD;
                st.prefix = {56'd0, byte_i | sqltok_pkg::CH_CASE};
                st.wcnt   = 4'd1;
              end
            end else begin
              tok_o[n] = mk_tok(sqltok_pkg::CLS_STRAY, pos, 32'd1, 32'd1, 1'b0);
              n = n + 2'd1;
            end
          end
        endcase
      end
    end

    // position advances, saturating
    if (pos != POS_MAX) pos = pos + OFFSET_BITS'(1);

    // last byte: flush the open token, then the end token, then start afresh
    if (last_i) begin
      case (st.mode)
        sqltok_pkg::MODE_ESC: begin
          tok_o[n] = mk_tok(sqltok_pkg::CLS_STR, start, st.raw_cnt,
                            sqltok_pkg::sat_inc(st.val_cnt), 1'b0);
          n = n + 2'd1;
        end
        sqltok_pkg::MODE_STR: begin
          tok_o[n] = mk_tok(sqltok_pkg::CLS_STR, start, st.raw_cnt, st.val_cnt, 1'b0);
          n = n + 2'd1;
        end
        sqltok_pkg::MODE_NUM: begin
          tok_o[n] = mk_tok(st.seen_dot ? sqltok_pkg::CLS_DEC : sqltok_pkg::CLS_INT,
                            start, st.raw_cnt, st.raw_cnt, 1'b0);
          n = n + 2'd1;
        end
        sqltok_pkg::MODE_WORD: begin
          tok_o[n] = mk_tok(sqltok_pkg::kw_class(st.prefix, st.wcnt),
                            start, st.raw_cnt, st.raw_cnt, 1'b0);
          n = n + 2'd1;
        end
        sqltok_pkg::MODE_MINUS: begin
          tok_o[n] = mk_tok(sqltok_pkg::CLS_STRAY, start, 32'd1, 32'd1, 1'b0);
          n = n + 2'd1;
        end
        sqltok_pkg::MODE_GT: begin
          tok_o[n] = mk_tok(sqltok_pkg::CLS_GT, start, 32'd1, 32'd1, 1'b0);
          n = n + 2'd1;
        end
        sqltok_pkg::MODE_LT: begin
          tok_o[n] = mk_tok(sqltok_pkg::CLS_LT, start, 32'd1, 32'd1, 1'b0);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      tok_o[n] = mk_tok(sqltok_pkg::CLS_STRAY, pos, '0, '0, 1'b1);
      n = n + 2'd1;
      st    = sqltok_pkg::SCAN_RESET;
      start = '0;
      pos   = '0;
    end

    st_o    = st;
    start_o = start;
    pos_o   = pos;
    cnt_o   = n;
  end

endmodule

`default_nettype wire

[design/sql_byte_tokenizer_core.sv]
// ---------------------------------------------------------------------------
// sql_byte_tokenizer_core: streaming sql lexer
// Byte stream in, token stream out, with input and result registers.
// ---------------------------------------------------------------------------
// One byte of query text is taken per beat and scanned combinationally
// between the input register and a three-entry result buffer; tokens reach
// the output through those two registers after their closing byte. Bytes
// that cause at most one token each stream at one per clock while the result
// side takes every token; a byte that causes k tokens (up to three, at the
// last byte of a text) holds the input until the single result port has
// given all k tokens, one per beat. Whitespace is dropped, the last byte of
// a text flushes any open token, adds an end token and restarts at offset 0.
`default_nettype none

module sql_byte_tokenizer_core #(
  parameter int OFFSET_BITS = sqltok_pkg::OFFSET_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input bytes
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] in_byte
  input  wire logic         in_tlast,   // in_last
  // result tokens
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // [5:0] token_class, [37:6] token_start,
                                        // [69:38] raw_length, [101:70] value_length
  output logic              out_tuser,  // end_of_text
  output logic              out_tlast   // last_of_run
);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // scanner state
  sqltok_pkg::scan_state_t st_r, st_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]  start_r, start_nxt;

  // result buffer
  sqltok_pkg::tok_t res_r [sqltok_pkg::RES_MAX];
  sqltok_pkg::tok_t res_nxt [sqltok_pkg::RES_MAX];
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       rd_r;

  logic out_beat, out_final, buf_free, adv;
  sqltok_pkg::tok_t cur_tok;

  sqltok_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .byte_i  (in_byte_r),
    .last_i  (in_last_r),
    .st_i    (st_r),
    .pos_i   (pos_r),
    .start_i (start_r),
    .st_o    (st_nxt),
    .pos_o   (pos_nxt),
    .start_o (start_nxt),
    .tok_o   (res_nxt),
    .cnt_o   (cnt_nxt)
  );

  // handshakes
  always_comb begin
    out_beat  = out_tvalid && out_tready;
    out_final = (rd_r == cnt_r - 2'd1);
    buf_free  = (rd_r == cnt_r) || (out_beat && out_final);
    adv       = in_vld_r && buf_free;
    in_tready = !in_vld_r || adv;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // scanner state and result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= sqltok_pkg::SCAN_RESET;
      pos_r   <= '0;
      start_r <= '0;
      cnt_r   <= 2'd0;
      rd_r    <= 2'd0;
    end else if (adv) begin
      st_r    <= st_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= 2'd0;
    end else if (out_beat) begin
      rd_r <= rd_r + 2'd1;
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < sqltok_pkg::RES_MAX; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  // output beat
  always_comb begin
    cur_tok    = res_r[rd_r];
    out_tvalid = (rd_r != cnt_r);
    out_tdata  = {2'b00, cur_tok.val, cur_tok.raw, cur_tok.start, cur_tok.cls};
    out_tuser  = cur_tok.eot;
    out_tlast  = out_final;
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: stream test of the sql byte tokenizer core
// Query text goes in one byte per beat while the result side stalls on its
// own pattern. Every token is checked field by field against a byte-level
// lexer kept in the bench; a short table of hand-picked bytes runs first,
// then random queries built from keywords, names, numbers, strings,
// punctuation, whitespace and noise.
// ---------------------------------------------------------------------------

module testbench;

  localparam int RANDOM_ITEMS = 200;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DIRECTED_N   = 24;

  localparam logic [71:0] PUNCT_SET = "(),;*.=<>";
  localparam logic [7:0]  CH_EQ     = "=";

  // one token as it leaves the block
  typedef struct packed {
    logic [sqltok_pkg::CLS_W-1:0] cls;
    logic [31:0]                  start;
    logic [31:0]                  raw;
    logic [31:0]                  val;
    logic                         eot;
    logic                         last;
  } token_t;

  // one input byte, with a hand-written first token where one is given
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    token_t     tok;
  } stim_t;

  typedef enum {READY_FULL, READY_MOSTLY, READY_SPARSE} stall_style_t;
  typedef enum {PART_IDENT, PART_NUMBER, PART_STRING, PART_PUNCT, PART_SPACE,
                PART_NOISE, PART_KEYWORD} query_part_t;

  localparam token_t NO_TOKEN = '0;

  logic         clk;
  logic         rst_n     = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata  = 8'h00;
  logic         in_tlast  = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;  // [5:0] class, [37:6] start, [69:38] raw, [101:70] value
  logic         out_tuser;  // end of text
  logic         out_tlast;  // last token of the byte

  sql_byte_tokenizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // keyword spellings, first letter in the highest byte
  logic [63:0]      keyword_text [32] = '{
    "by", "on", "or", "if", "int", "asc", "and", "key", "not", "from", "join",
    "desc", "null", "into", "text", "table", "where", "order", "float", "inner",
    "create", "insert", "select", "delete", "double", "exists", "values",
    "primary", "integer", "varchar", "decimal", "datetime"};
  logic [sqltok_pkg::CLS_W-1:0] keyword_code [32] = '{
    sqltok_pkg::CLS_KW_BY, sqltok_pkg::CLS_KW_ON, sqltok_pkg::CLS_KW_OR,
    sqltok_pkg::CLS_KW_IF, sqltok_pkg::CLS_KW_INT, sqltok_pkg::CLS_KW_ASC,
    sqltok_pkg::CLS_KW_AND, sqltok_pkg::CLS_KW_KEY, sqltok_pkg::CLS_KW_NOT,
    sqltok_pkg::CLS_KW_FROM, sqltok_pkg::CLS_KW_JOIN, sqltok_pkg::CLS_KW_DESC,
    sqltok_pkg::CLS_KW_NULL, sqltok_pkg::CLS_KW_INTO, sqltok_pkg::CLS_KW_TEXT,
    sqltok_pkg::CLS_KW_TABLE, sqltok_pkg::CLS_KW_WHERE, sqltok_pkg::CLS_KW_ORDER,
    sqltok_pkg::CLS_KW_FLOAT, sqltok_pkg::CLS_KW_INNER, sqltok_pkg::CLS_KW_CREATE,
    sqltok_pkg::CLS_KW_INSERT, sqltok_pkg::CLS_KW_SELECT, sqltok_pkg::CLS_KW_DELETE,
    sqltok_pkg::CLS_KW_FLOAT, sqltok_pkg::CLS_KW_EXISTS, sqltok_pkg::CLS_KW_VALUES,
    sqltok_pkg::CLS_KW_PRIMARY, sqltok_pkg::CLS_KW_INT, sqltok_pkg::CLS_KW_VARCHAR,
    sqltok_pkg::CLS_KW_FLOAT, sqltok_pkg::CLS_KW_DATETIME};

  // lexer state of the bench
  sqltok_pkg::mode_t lex_mode = sqltok_pkg::MODE_IDLE;
  logic        lex_dquote = 1'b0;
  logic        lex_dot    = 1'b0;
  logic [63:0] lex_word   = '0;   // lower-cased, last byte lowest
  logic [3:0]  lex_wlen   = '0;
  logic [31:0] lex_pos    = '0;
  logic [31:0] lex_start  = '0;
  logic [31:0] lex_raw    = '0;
  logic [31:0] lex_val    = '0;

  token_t      step_out [3];
  int          step_n;
  token_t      tokens_due [$];

  stim_t       directed_rows [DIRECTED_N];
  stim_t       cur_row = '0;
  logic [7:0]  query_bytes [$];
  int          burst_left   = 0;
  int          random_items = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  stall_style_t ready_style = READY_FULL;
  int          ready_left   = 0;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == sqltok_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [31:0] len_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // words of more than eight bytes never match
  function automatic logic [sqltok_pkg::CLS_W-1:0] keyword_of(input logic [63:0] w,
                                                              input logic [3:0]  n);
    logic [sqltok_pkg::CLS_W-1:0] found;
    found = sqltok_pkg::CLS_IDENT;
    if (n <= 4'd8) begin
      for (int k = 0; k < 32; k++)
        if (keyword_text[k] == w) found = keyword_code[k];
    end
    return found;
  endfunction

  task automatic lex_emit(input logic [sqltok_pkg::CLS_W-1:0] cls,
                          input logic [31:0] start,
                          input logic [31:0] raw, input logic [31:0] val,
                          input logic eot);
    if (step_n < 3) begin
      step_out[step_n] = {cls, start, raw, val, eot, 1'b0};
      step_n++;
    end
  endtask

  task automatic lex_emit_open(input logic [sqltok_pkg::CLS_W-1:0] cls);
    lex_emit(cls, lex_start, lex_raw, lex_raw, 1'b0);
  endtask

  task automatic lex_open(input sqltok_pkg::mode_t mode);
    lex_mode  = mode;
    lex_start = lex_pos;
    lex_raw   = 32'd1;
    lex_val   = 32'd0;
    lex_dot   = 1'b0;
    lex_word  = '0;
    lex_wlen  = 4'd0;
  endtask

  // a byte seen with no token open
  task automatic lex_idle(input logic [7:0] c);
    lex_mode = sqltok_pkg::MODE_IDLE;
    if (!is_space(c)) begin
      case (c)
        "(":      lex_emit(sqltok_pkg::CLS_LPAREN, lex_pos, 32'd1, 32'd1, 1'b0);
        ")":      lex_emit(sqltok_pkg::CLS_RPAREN, lex_pos, 32'd1, 32'd1, 1'b0);
        ",":      lex_emit(sqltok_pkg::CLS_COMMA, lex_pos, 32'd1, 32'd1, 1'b0);
        ";":      lex_emit(sqltok_pkg::CLS_SEMI, lex_pos, 32'd1, 32'd1, 1'b0);
        "*":      lex_emit(sqltok_pkg::CLS_STAR, lex_pos, 32'd1, 32'd1, 1'b0);
        sqltok_pkg::CH_DOT:
          lex_emit(sqltok_pkg::CLS_DOT, lex_pos, 32'd1, 32'd1, 1'b0);
        CH_EQ:    lex_emit(sqltok_pkg::CLS_EQ, lex_pos, 32'd1, 32'd1, 1'b0);
        ">":      lex_open(sqltok_pkg::MODE_GT);
        "<":      lex_open(sqltok_pkg::MODE_LT);
        sqltok_pkg::CH_MINUS: lex_open(sqltok_pkg::MODE_MINUS);
        sqltok_pkg::CH_SQUOTE, sqltok_pkg::CH_DQUOTE: begin
          lex_open(sqltok_pkg::MODE_STR);
          lex_dquote = (c == sqltok_pkg::CH_DQUOTE);
        end
        default: begin
          if (is_digit(c)) begin
            lex_open(sqltok_pkg::MODE_NUM);
          end else if (is_alpha(c) || c == sqltok_pkg::CH_USCORE) begin
            lex_open(sqltok_pkg::MODE_WORD);
            lex_word = {56'd0, c | sqltok_pkg::CH_CASE};
            lex_wlen = 4'd1;
          end else begin
            lex_emit(sqltok_pkg::CLS_STRAY, lex_pos, 32'd1, 32'd1, 1'b0);
          end
        end
      endcase
    end
  endtask

  // tokens caused by one accepted byte, left in step_out
  task automatic tokenise_byte(input logic [7:0] c, input logic fin);
    step_n = 0;
    case (lex_mode)
      sqltok_pkg::MODE_STR: begin
        lex_raw = len_inc(lex_raw);
        if (c == (lex_dquote ? sqltok_pkg::CH_DQUOTE : sqltok_pkg::CH_SQUOTE)) begin
          lex_emit(sqltok_pkg::CLS_STR, lex_start, lex_raw, lex_val, 1'b0);
          lex_mode = sqltok_pkg::MODE_IDLE;
        end else if (c == sqltok_pkg::CH_BSLASH) begin
          lex_mode = sqltok_pkg::MODE_ESC;
        end else begin
          lex_val = len_inc(lex_val);
        end
      end
      sqltok_pkg::MODE_ESC: begin
        lex_raw  = len_inc(lex_raw);
        lex_val  = len_inc(lex_val);
        lex_mode = sqltok_pkg::MODE_STR;
      end
      sqltok_pkg::MODE_NUM: begin
        if (is_digit(c) || (c == sqltok_pkg::CH_DOT && !lex_dot)) begin
          if (c == sqltok_pkg::CH_DOT) lex_dot = 1'b1;
          lex_raw = len_inc(lex_raw);
        end else begin
          lex_emit_open(lex_dot ? sqltok_pkg::CLS_DEC : sqltok_pkg::CLS_INT);
          lex_idle(c);
        end
      end
      sqltok_pkg::MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == sqltok_pkg::CH_USCORE) begin
          if (lex_wlen < 4'd8) lex_word = {lex_word[55:0], c | sqltok_pkg::CH_CASE};
          if (lex_wlen < 4'd9) lex_wlen = lex_wlen + 4'd1;
          lex_raw = len_inc(lex_raw);
        end else begin
          lex_emit_open(keyword_of(lex_word, lex_wlen));
          lex_idle(c);
        end
      end
      sqltok_pkg::MODE_MINUS: begin
        if (is_digit(c)) begin
          lex_mode = sqltok_pkg::MODE_NUM;
          lex_raw  = 32'd2;
          lex_dot  = 1'b0;
        end else begin
          lex_emit(sqltok_pkg::CLS_STRAY, lex_start, 32'd1, 32'd1, 1'b0);
          lex_idle(c);
        end
      end
      sqltok_pkg::MODE_GT, sqltok_pkg::MODE_LT: begin
        if (c == CH_EQ) begin
          lex_emit((lex_mode == sqltok_pkg::MODE_GT) ? sqltok_pkg::CLS_GE
                                                     : sqltok_pkg::CLS_LE,
                   lex_start, 32'd2, 32'd2, 1'b0);
          lex_mode = sqltok_pkg::MODE_IDLE;
        end else begin
          lex_emit((lex_mode == sqltok_pkg::MODE_GT) ? sqltok_pkg::CLS_GT
                                                     : sqltok_pkg::CLS_LT,
                   lex_start, 32'd1, 32'd1, 1'b0);
          lex_idle(c);
        end
      end
      default: lex_idle(c);
    endcase
    if (lex_pos != 32'hFFFF_FFFF) lex_pos = lex_pos + 32'd1;

    // last byte: close any open token, add the end token, start afresh
    if (fin) begin
      case (lex_mode)
        sqltok_pkg::MODE_STR, sqltok_pkg::MODE_ESC: begin
          if (lex_mode == sqltok_pkg::MODE_ESC) lex_val = len_inc(lex_val);
          lex_emit(sqltok_pkg::CLS_STR, lex_start, lex_raw, lex_val, 1'b0);
        end
        sqltok_pkg::MODE_NUM:
          lex_emit_open(lex_dot ? sqltok_pkg::CLS_DEC : sqltok_pkg::CLS_INT);
        sqltok_pkg::MODE_WORD:
          lex_emit_open(keyword_of(lex_word, lex_wlen));
        sqltok_pkg::MODE_MINUS:
          lex_emit(sqltok_pkg::CLS_STRAY, lex_start, 32'd1, 32'd1, 1'b0);
        sqltok_pkg::MODE_GT:
          lex_emit(sqltok_pkg::CLS_GT, lex_start, 32'd1, 32'd1, 1'b0);
        sqltok_pkg::MODE_LT:
          lex_emit(sqltok_pkg::CLS_LT, lex_start, 32'd1, 32'd1, 1'b0);
        default: ;
      endcase
      lex_emit(sqltok_pkg::CLS_STRAY, lex_pos, 32'd0, 32'd0, 1'b1);
      lex_mode   = sqltok_pkg::MODE_IDLE;
      lex_dquote = 1'b0;
      lex_dot    = 1'b0;
      lex_word   = '0;
      lex_wlen   = 4'd0;
      lex_pos    = 32'd0;
      lex_start  = 32'd0;
      lex_raw    = 32'd0;
      lex_val    = 32'd0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result beats against the oldest token due, then predict on input beats
  always @(posedge clk) begin : token_check
    token_t got;
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[5:0], out_tdata[37:6], out_tdata[69:38], out_tdata[101:70],
             out_tuser, out_tlast};
      if (tokens_due.size() == 0) begin
        $error("token beat with nothing due: class %0d start %0d", got.cls, got.start);
        mismatches++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_class", 32'(want.cls), 32'(got.cls));
        check_field("token_start", want.start, got.start);
        check_field("raw_length", want.raw, got.raw);
        check_field("value_length", want.val, got.val);
        check_field("end_of_text", 32'(want.eot), 32'(got.eot));
        check_field("last_of_run", 32'(want.last), 32'(got.last));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      tokenise_byte(in_tdata, in_tlast);
      for (int k = 0; k < step_n; k++) begin
        want = step_out[k];
        want.last = (k == step_n - 1);
        // hand-written first token takes the place of the predicted one
        if (k == 0 && cur_row.typed) begin
          want.cls   = cur_row.tok.cls;
          want.start = cur_row.tok.start;
          want.raw   = cur_row.tok.raw;
          want.val   = cur_row.tok.val;
          want.eot   = cur_row.tok.eot;
        end
        tokens_due = {tokens_due, want};
      end
    end
  end

  // receiver stalls in phases of varying density
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_style = stall_style_t'($urandom_range(0, 2));
      ready_left  = $urandom_range(8, 60);
    end else begin
      ready_left = ready_left - 1;
    end
    case (ready_style)
      READY_FULL:   out_tready <= 1'b1;
      READY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      default:      out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte per call, in bursts with random gaps between them
  task automatic send_row(input stim_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.ch;
    in_tlast  <= row.fin;
    cur_row   <= row;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // sender holds off until every token due has come
  task automatic hold_until_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tokens_due.size() != 0);
  endtask

  // add one byte to the end of the query text
  task automatic append_byte(input logic [7:0] b);
    query_bytes = {query_bytes, b};
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    return ($urandom_range(0, 1) == 1) ? (c ^ sqltok_pkg::CH_CASE) : c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return flip_case(8'(8'h61 + $urandom_range(0, 25)));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    return ($urandom_range(0, 2) == 0) ? 8'(8'h09 + $urandom_range(0, 4))
                                       : sqltok_pkg::CH_SPACE;
  endfunction

  // one random query text into query_bytes
  task automatic compose_query();
    int parts;
    int pick;
    query_part_t part;
    logic [63:0] spell;
    logic [7:0] quote;
    query_bytes.delete();
    parts = $urandom_range(1, 10);
    for (int p = 0; p < parts; p++) begin
      pick = $urandom_range(0, 8);
      part = (pick > 6) ? PART_KEYWORD : query_part_t'(pick);
      case (part)
        PART_KEYWORD: begin
          spell = keyword_text[$urandom_range(0, 31)];
          for (int b = 7; b >= 0; b--)
            if (spell[8*b +: 8] != 8'h00) append_byte(flip_case(spell[8*b +: 8]));
        end
        PART_IDENT: begin
          append_byte(($urandom_range(0, 5) == 0) ? sqltok_pkg::CH_USCORE : rand_letter());
          repeat ($urandom_range(0, 11)) begin
            pick = $urandom_range(0, 3);
            append_byte((pick == 3) ? sqltok_pkg::CH_USCORE :
                        (pick == 2) ? rand_digit() : rand_letter());
          end
        end
        PART_NUMBER: begin
          if ($urandom_range(0, 3) == 0) append_byte(sqltok_pkg::CH_MINUS);
          repeat ($urandom_range(1, 5)) append_byte(rand_digit());
          if ($urandom_range(0, 2) == 0) begin
            append_byte(sqltok_pkg::CH_DOT);
            repeat ($urandom_range(0, 3)) append_byte(rand_digit());
            if ($urandom_range(0, 4) == 0) append_byte(sqltok_pkg::CH_DOT);
          end
        end
        PART_STRING: begin
          quote = ($urandom_range(0, 1) == 1) ? sqltok_pkg::CH_DQUOTE
                                              : sqltok_pkg::CH_SQUOTE;
          append_byte(quote);
          repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 5) == 0) append_byte(sqltok_pkg::CH_BSLASH);
            append_byte(8'($urandom_range(0, 255)));
          end
          // the last string of a text is sometimes left open
          if (p != parts - 1 || $urandom_range(0, 3) != 0) append_byte(quote);
        end
        PART_PUNCT: begin
          pick = $urandom_range(0, 10);
          if (pick < 9) begin
            append_byte(PUNCT_SET[8*pick +: 8]);
          end else begin
            append_byte(PUNCT_SET[8*(pick-9) +: 8]);
            append_byte(CH_EQ);
          end
        end
        PART_SPACE: repeat ($urandom_range(1, 3)) append_byte(rand_space());
        default:    append_byte(8'($urandom_range(0, 255)));
      endcase
      // separator, sometimes none so that tokens run together
      pick = $urandom_range(0, 3);
      if (pick < 2) append_byte(sqltok_pkg::CH_SPACE);
      else if (pick == 3) append_byte(rand_space());
    end
  endtask

  initial begin
    stim_t row;
    directed_rows = '{
      // stray bytes at both ends of the byte range, punctuation, blank
      {8'h00, 1'b0, 1'b1, sqltok_pkg::CLS_STRAY, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0},
      {8'hFF, 1'b0, 1'b1, sqltok_pkg::CLS_STRAY, 32'd1, 32'd1, 32'd1, 1'b0, 1'b0},
      {8'h28, 1'b0, 1'b1, sqltok_pkg::CLS_LPAREN, 32'd2, 32'd1, 32'd1, 1'b0, 1'b0},
      {sqltok_pkg::CH_SPACE, 1'b0, 1'b0, NO_TOKEN},
      // signed decimal cut short by a second dot
      {sqltok_pkg::CH_MINUS, 1'b0, 1'b0, NO_TOKEN},
      {8'h37, 1'b0, 1'b0, NO_TOKEN},
      {sqltok_pkg::CH_DOT, 1'b0, 1'b0, NO_TOKEN},
      {8'h35, 1'b0, 1'b0, NO_TOKEN},
      {sqltok_pkg::CH_DOT, 1'b0, 1'b0, NO_TOKEN},
      // minus with no digit behind it, then a name and a comparator
      {sqltok_pkg::CH_MINUS, 1'b0, 1'b0, NO_TOKEN},
      {8'h71, 1'b0, 1'b1, sqltok_pkg::CLS_STRAY, 32'd9, 32'd1, 32'd1, 1'b0, 1'b0},
      {8'h3E, 1'b0, 1'b0, NO_TOKEN},
      {CH_EQ, 1'b0, 1'b1, sqltok_pkg::CLS_GE, 32'd11, 32'd2, 32'd2, 1'b0, 1'b0},
      // escaped quote, then a backslash as the last byte
      {sqltok_pkg::CH_SQUOTE, 1'b0, 1'b0, NO_TOKEN},
      {sqltok_pkg::CH_BSLASH, 1'b0, 1'b0, NO_TOKEN},
      {sqltok_pkg::CH_SQUOTE, 1'b0, 1'b0, NO_TOKEN},
      {8'h41, 1'b0, 1'b0, NO_TOKEN},
      {sqltok_pkg::CH_BSLASH, 1'b1, 1'b0, NO_TOKEN},
      // minus as the last byte, and a lone less-than
      {sqltok_pkg::CH_MINUS, 1'b1, 1'b1, sqltok_pkg::CLS_STRAY, 32'd0, 32'd1, 32'd1,
       1'b0, 1'b0},
      {8'h3C, 1'b1, 1'b1, sqltok_pkg::CLS_LT, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0},
      // double-quoted string still open at the end
      {sqltok_pkg::CH_DQUOTE, 1'b0, 1'b0, NO_TOKEN},
      {8'h78, 1'b0, 1'b0, NO_TOKEN},
      {8'h7F, 1'b1, 1'b0, NO_TOKEN},
      {8'h39, 1'b1, 1'b1, sqltok_pkg::CLS_INT, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    hold_until_drained();

    // random query texts
    while (random_items < RANDOM_ITEMS) begin
      compose_query();
      foreach (query_bytes[i]) begin
        row = {query_bytes[i], i == query_bytes.size() - 1, 1'b0, NO_TOKEN};
        random_items++;
        send_row(row);
      end
      if ($urandom_range(0, 5) == 0) hold_until_drained();
    end

    // drain, then watch the output for anything unexpected before the verdict
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/sqltok_pkg.sv
design/sqltok_scan.sv
design/sql_byte_tokenizer_core.sv
tb/testbench.sv
